/* hw/rtl/whk_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// whk_pkg: shared types, constants and round functions of the word hash
// Holds the a/b/c triple, the messages between the absorb, mix and final
// units, and the rotate/subtract rounds split into register-sized pieces.
// ----------------------------------------------------------------------------
package whk_pkg;

   localparam int HashW   = 32;
   localparam int CountW  = 16;
   localparam int BucketW = 8;

   localparam logic [HashW-1:0] HashInit = 32'hdeadbeef;

   // output queue
   localparam int FifoDepth = 8;
   localparam int FifoAw    = $clog2(FifoDepth);

   // slot that the next key word is added to
   localparam logic [1:0] SlotA = 2'd0;
   localparam logic [1:0] SlotB = 2'd1;
   localparam logic [1:0] SlotC = 2'd2;

   typedef struct packed {
      logic [HashW-1:0] a;
      logic [HashW-1:0] b;
      logic [HashW-1:0] c;
   } abc_type;

   typedef struct packed {
      logic    valid;
      abc_type abc;
   } abc_msg_type;

   typedef struct packed {
      logic    valid;
      logic    raw;    // empty key: pass the start value without final rounds
      abc_type abc;
   } fin_msg_type;

   function automatic logic [HashW-1:0] rotl(input logic [HashW-1:0] x, input int unsigned n);
      return (x << n) | (x >> (HashW - n));
   endfunction

   // mix rounds one to three
   function automatic abc_type mix_head(input abc_type x);
      abc_type s;
      s = x;
      s.a = (s.a - s.c) ^ rotl(s.c, 4);  s.c = s.c + s.b;
      s.b = (s.b - s.a) ^ rotl(s.a, 6);  s.a = s.a + s.c;
      s.c = (s.c - s.b) ^ rotl(s.b, 8);  s.b = s.b + s.a;
      return s;
   endfunction

   // mix rounds four to six
   function automatic abc_type mix_tail(input abc_type x);
      abc_type s;
      s = x;
      s.a = (s.a - s.c) ^ rotl(s.c, 16); s.c = s.c + s.b;
      s.b = (s.b - s.a) ^ rotl(s.a, 19); s.a = s.a + s.c;
      s.c = (s.c - s.b) ^ rotl(s.b, 4);  s.b = s.b + s.a;
      return s;
   endfunction

   function automatic abc_type final_head(input abc_type x);
      abc_type s;
      s = x;
      s.c = (s.c ^ s.b) - rotl(s.b, 14);
      s.a = (s.a ^ s.c) - rotl(s.c, 11);
      s.b = (s.b ^ s.a) - rotl(s.a, 25);
      return s;
   endfunction

   function automatic abc_type final_mid(input abc_type x);
      abc_type s;
      s = x;
      s.c = (s.c ^ s.b) - rotl(s.b, 16);
      s.a = (s.a ^ s.c) - rotl(s.c, 4);
      return s;
   endfunction

   function automatic abc_type final_tail(input abc_type x);
      abc_type s;
      s = x;
      s.b = (s.b ^ s.a) - rotl(s.a, 14);
      s.c = (s.c ^ s.b) - rotl(s.b, 24);
      return s;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/whk_absorb.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// whk_absorb: key word intake
// Tracks key length and group slot, keeps the a/b/c base and the words of
// the open group, launches a mix after each inner group and hands the sum
// of base and words to the final rounds when the key ends.
// ----------------------------------------------------------------------------
module whk_absorb (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     take,
   input  wire logic [31:0]              key_word,
   input  wire logic                     first_word,
   input  wire logic [15:0]              word_count,
   input  wire logic [31:0]              seed,
   input  wire whk_pkg::abc_msg_type     mix_done,
   output whk_pkg::abc_msg_type          mix_launch,
   output logic                          mix_cancel,
   output whk_pkg::fin_msg_type          fin,
   output logic                          last_due
);
   import whk_pkg::*;

   abc_type          base_ff, base_in;
   logic [HashW-1:0] pa_ff, pa_in;
   logic [HashW-1:0] pb_ff, pb_in;
   logic [CountW-1:0] left_ff, left_in;
   logic [1:0]       pos_ff, pos_in;
   fin_msg_type      fin_ff, fin_in;

   logic [HashW-1:0]  init_val;
   abc_type           init_abc;
   abc_type           eff;
   abc_type           sum_abc;
   logic [1:0]        eff_pos;
   logic [1:0]        pos_next;
   logic [CountW-1:0] eff_left;
   logic [CountW-1:0] left_next;
   logic              is_first;
   logic              is_empty;
   logic              active;
   logic              is_last;
   logic              slot_a;
   logic              slot_b;
   logic              slot_c;

   always_comb begin
      init_val = HashInit + {14'd0, word_count, 2'b00} + seed;
      init_abc = '{a: init_val, b: init_val, c: init_val};
      is_first = take && first_word;
      is_empty = is_first && (word_count == '0);
      eff      = is_first ? init_abc : base_ff;
      eff_pos  = is_first ? SlotA : pos_ff;
      eff_left = is_first ? word_count : left_ff;
      active   = take && (eff_left != '0);
      left_next = eff_left - 16'd1;
      is_last  = active && (left_next == '0);
   end

   // slot three never occurs, it is handled like slot a
   always_comb begin
      slot_a   = 1'b0;
      slot_b   = 1'b0;
      slot_c   = 1'b0;
      pos_next = SlotB;
      case (eff_pos)
         SlotB: begin
            slot_b   = 1'b1;
            pos_next = SlotC;
         end
         SlotC: begin
            slot_c   = 1'b1;
            pos_next = SlotA;
         end
         default: begin
            slot_a   = 1'b1;
            pos_next = SlotB;
         end
      endcase
   end

   // base plus the words of the open group, unreceived slots add nothing
   always_comb begin
      sum_abc.a = eff.a + (slot_a ? key_word : pa_ff);
      sum_abc.b = eff.b + (slot_b ? key_word : (slot_c ? pb_ff : '0));
      sum_abc.c = eff.c + (slot_c ? key_word : '0);
   end

   always_comb begin
      mix_launch.valid = active && slot_c && !is_last;
      mix_launch.abc.a = base_ff.a + pa_ff;
      mix_launch.abc.b = base_ff.b + pb_ff;
      mix_launch.abc.c = base_ff.c + key_word;
      mix_cancel       = is_first;
   end

   always_comb begin
      fin_in.valid = is_empty || is_last;
      fin_in.raw   = is_empty;
      fin_in.abc   = is_empty ? init_abc : sum_abc;

      base_in = base_ff;
      if (is_first) begin
         base_in = init_abc;
      end else if (mix_done.valid) begin
         base_in = mix_done.abc;
      end

      pa_in   = pa_ff;
      pb_in   = pb_ff;
      left_in = eff_left;
      pos_in  = eff_pos;
      if (active) begin
         left_in = left_next;
         pos_in  = is_last ? SlotA : pos_next;
         if (slot_a) begin
            pa_in = key_word;
         end
         if (slot_b) begin
            pb_in = key_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= '0;
         left_ff   <= '0;
         pos_ff    <= SlotA;
         fin_ff.valid <= 1'b0;
      end else begin
         base_ff   <= base_in;
         left_ff   <= left_in;
         pos_ff    <= pos_in;
         fin_ff.valid <= fin_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      pa_ff      <= pa_in;
      pb_ff      <= pb_in;
      fin_ff.raw <= fin_in.raw;
      fin_ff.abc <= fin_in.abc;
   end

   assign fin      = fin_ff;
   assign last_due = (left_ff == 16'd1);

endmodule
`default_nettype wire

/* hw/rtl/whk_mix.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// whk_mix: reversible mix unit
// Two register stages of three rounds each; a new key drops the mix in flight.
// ----------------------------------------------------------------------------
module whk_mix (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire whk_pkg::abc_msg_type launch,
   input  wire logic                 cancel,
   output whk_pkg::abc_msg_type      done,
   output logic                      busy
);
   import whk_pkg::*;

   abc_msg_type m1_ff, m1_in;
   abc_msg_type m2_ff, m2_in;

   always_comb begin
      m1_in.valid = launch.valid && !cancel;
      m1_in.abc   = launch.abc;
      m2_in.valid = m1_ff.valid && !cancel;
      m2_in.abc   = mix_head(m1_ff.abc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_ff.valid <= 1'b0;
         m2_ff.valid <= 1'b0;
      end else begin
         m1_ff.valid <= m1_in.valid;
         m2_ff.valid <= m2_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      m1_ff.abc <= m1_in.abc;
      m2_ff.abc <= m2_in.abc;
   end

   assign done.valid = m2_ff.valid;
   assign done.abc   = mix_tail(m2_ff.abc);
   assign busy       = m1_ff.valid || m2_ff.valid;

endmodule
`default_nettype wire

/* hw/rtl/whk_final.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// whk_final: final rounds pipeline
// Seven rounds over three stages; empty keys pass through untouched.
// ----------------------------------------------------------------------------
module whk_final (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire whk_pkg::fin_msg_type fin,
   output logic                      res_valid,
   output logic [31:0]               res_hash,
   output logic [1:0]                inflight
);
   import whk_pkg::*;

   fin_msg_type s2_ff, s2_in;
   fin_msg_type s3_ff, s3_in;
   abc_type     tail_abc;

   always_comb begin
      s2_in.valid = fin.valid;
      s2_in.raw   = fin.raw;
      s2_in.abc   = fin.raw ? fin.abc : final_head(fin.abc);
      s3_in.valid = s2_ff.valid;
      s3_in.raw   = s2_ff.raw;
      s3_in.abc   = s2_ff.raw ? s2_ff.abc : final_mid(s2_ff.abc);
      tail_abc    = s3_ff.raw ? s3_ff.abc : final_tail(s3_ff.abc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
      end else begin
         s2_ff.valid <= s2_in.valid;
         s3_ff.valid <= s3_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      s2_ff.raw <= s2_in.raw;
      s2_ff.abc <= s2_in.abc;
      s3_ff.raw <= s3_in.raw;
      s3_ff.abc <= s3_in.abc;
   end

   assign res_valid = s3_ff.valid;
   assign res_hash  = tail_abc.c;
   assign inflight  = 2'({1'b0, fin.valid}) + 2'({1'b0, s2_ff.valid})
                    + 2'({1'b0, s3_ff.valid});

endmodule
`default_nettype wire

/* hw/rtl/whk_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// whk_fifo: result queue
// Small queue between the final rounds and the result channel; the intake
// reserves room for every item still in the final rounds.
// ----------------------------------------------------------------------------
module whk_fifo (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire logic [31:0]               push_data,
   input  wire logic                      pop,
   output logic                           out_valid,
   output logic [31:0]                    out_data,
   output logic [whk_pkg::FifoAw:0]       count
);
   import whk_pkg::*;

   logic [HashW-1:0]  mem_ff [FifoDepth];
   logic [FifoAw-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FifoAw-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FifoAw:0]   count_ff, count_in;
   logic              do_pop;

   always_comb begin
      do_pop    = pop && (count_ff != '0);
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (FifoAw+1)'(push) - (FifoAw+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule
`default_nettype wire

/* hw/rtl/word_array_hash.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// word_array_hash: streaming word-array hash (lookup3 hashword)
// A key enters as one item per 32-bit word on the req_ channel. The first
// item of a key carries req_first_word=1, the key length in words and the
// seed; an empty key is one item that returns the start value. The rsp_
// channel returns one item per finished key: the hash and its bucket index.
// Throughput: one word per cycle while req_ready is high. The mix after each
// inner group of three words runs in a two-stage unit beside the intake; the
// final word of a key waits for it, so a key whose last group is short stalls.
// A result passes the intake register, two final-round registers and the
// result queue before it is on rsp_.
// Reset clears the key state and the queue; words that arrive outside a key
// are taken and dropped. When the receiver stalls, results collect in the
// queue and req_ready falls only once the queue has no room for items still
// in the final rounds.
// ----------------------------------------------------------------------------
module word_array_hash #(
   parameter int BUCKET_BITS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_key_word,
   input  wire logic        req_first_word,
   input  wire logic [15:0] req_word_count,
   input  wire logic [31:0] req_seed,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_hash_value,
   output logic [7:0]       rsp_bucket_index
);
   import whk_pkg::*;

   localparam int MaskBits = (BUCKET_BITS < BucketW) ? BUCKET_BITS : BucketW;
   localparam logic [BucketW-1:0] BucketMask = BucketW'((9'd1 << MaskBits) - 9'd1);

   abc_msg_type     mix_launch;
   abc_msg_type     mix_done;
   fin_msg_type     fin;
   logic            mix_cancel;
   logic            mix_busy;
   logic            last_due;
   logic            take;
   logic            res_valid;
   logic [HashW-1:0] res_hash;
   logic [1:0]      inflight;
   logic [FifoAw:0] fifo_count;
   logic [FifoAw:0] reserved;
   logic            room;

   always_comb begin
      reserved  = fifo_count + (FifoAw+1)'(inflight);
      room      = reserved < (FifoAw+1)'(FifoDepth);
      // the last word of a key needs the mix result in the base
      req_ready = room && !(mix_busy && last_due);
      take      = req_valid && req_ready;
   end

   whk_absorb u_absorb (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .key_word   (req_key_word),
      .first_word (req_first_word),
      .word_count (req_word_count),
      .seed       (req_seed),
      .mix_done   (mix_done),
      .mix_launch (mix_launch),
      .mix_cancel (mix_cancel),
      .fin        (fin),
      .last_due   (last_due)
   );

   whk_mix u_mix (
      .clock  (clock),
      .reset  (reset),
      .launch (mix_launch),
      .cancel (mix_cancel),
      .done   (mix_done),
      .busy   (mix_busy)
   );

   whk_final u_final (
      .clock     (clock),
      .reset     (reset),
      .fin       (fin),
      .res_valid (res_valid),
      .res_hash  (res_hash),
      .inflight  (inflight)
   );

   whk_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res_hash),
      .pop       (rsp_ready),
      .out_valid (rsp_valid),
      .out_data  (rsp_hash_value),
      .count     (fifo_count)
   );

   assign rsp_bucket_index = rsp_hash_value[BucketW-1:0] & BucketMask;

   // reserved queue room covers every item in the final rounds
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      reserved <= (FifoAw+1)'(FifoDepth))
      else $error("result queue over-committed");

   // a group takes three words, so the mix unit is idle at each launch
   a_mix_idle_at_launch: assert property (@(posedge clock) disable iff (reset)
      mix_launch.valid |-> !mix_busy)
      else $error("mix launched while busy");

   // an empty key gives a raw result in the next cycle
   a_empty_key: assert property (@(posedge clock) disable iff (reset)
      (take && req_first_word && req_word_count == '0) |=> (fin.valid && fin.raw))
      else $error("empty key lost");

   // the final rounds never see a key word while a mix is still open
   a_no_final_during_mix: assert property (@(posedge clock) disable iff (reset)
      (fin.valid && !fin.raw) |-> !$past(mix_busy && !mix_cancel))
      else $error("key finished during mix");

endmodule
`default_nettype wire

/* bench/word_array_hash_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_array_hash_tb: self-checking bench for the streaming word-array hash
// Drives keys word by word on req_, predicts each hash with a local lookup3
// model and compares every rsp_ item in order. A short stimulus table comes
// first, then random keys (whole, abandoned and stray words) under several
// idling patterns, and a long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module word_array_hash_tb;
   import whk_pkg::*;

   localparam int BUCKET_BITS = 8;

   typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_type;

   typedef struct packed {
      logic [31:0] hash;
      logic [7:0]  bucket;
   } hash_result_type;

   typedef struct packed {
      logic [31:0] word;
      logic        first;
      logic [15:0] count;
      logic [31:0] seed;
      logic        fixed;
      logic [31:0] fixed_hash;
      logic [7:0]  fixed_bucket;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_key_word = '0;
   logic        req_first_word = 1'b0;
   logic [15:0] req_word_count = '0;
   logic [31:0] req_seed = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_hash_value;
   logic [7:0]  rsp_bucket_index;

   // typed-in expectation travelling with the item on req_
   logic        drv_fixed = 1'b0;
   logic [31:0] drv_fixed_hash = '0;
   logic [7:0]  drv_fixed_bucket = '0;

   idle_mode_type   idle_mode = IdleNone;
   bit              hold_start = 1'b0;
   int              hold_left = 0;
   int              fail_count = 0;
   hash_result_type due_hashes[$];

   // predictor state
   abc_type     key_abc = '0;
   logic [15:0] key_words_left = '0;
   logic [1:0]  key_slot = SlotA;

   stim_row_type directed [21] = '{
      // stray word right after reset
      '{32'hffffffff, 1'b0, 16'hffff, 32'hffffffff, 1'b0, 32'h0, 8'h00},
      // empty keys: start value comes straight back
      '{32'h00000000, 1'b1, 16'h0000, 32'h00000000, 1'b1, 32'hdeadbeef, 8'hef},
      '{32'hffffffff, 1'b1, 16'h0000, 32'hffffffff, 1'b1, 32'hdeadbeee, 8'hee},
      '{32'h12345678, 1'b1, 16'h0000, 32'h21524111, 1'b1, 32'h00000000, 8'h00},
      // one-word keys
      '{32'h00000000, 1'b1, 16'h0001, 32'h00000000, 1'b0, 32'h0, 8'h00},
      '{32'hffffffff, 1'b1, 16'h0001, 32'hffffffff, 1'b0, 32'h0, 8'h00},
      // exactly one group, no inner mix
      '{32'h00000001, 1'b1, 16'h0003, 32'h00000000, 1'b0, 32'h0, 8'h00},
      '{32'h00000002, 1'b0, 16'h0000, 32'h00000000, 1'b0, 32'h0, 8'h00},
      '{32'h00000003, 1'b0, 16'h0000, 32'h00000000, 1'b0, 32'h0, 8'h00},
      // four words: inner mix, then final rounds on a short group
      '{32'hffffffff, 1'b1, 16'h0004, 32'ha5a5a5a5, 1'b0, 32'h0, 8'h00},
      '{32'hffffffff, 1'b0, 16'hffff, 32'hffffffff, 1'b0, 32'h0, 8'h00},
      '{32'hffffffff, 1'b0, 16'hffff, 32'hffffffff, 1'b0, 32'h0, 8'h00},
      '{32'hffffffff, 1'b0, 16'hffff, 32'hffffffff, 1'b0, 32'h0, 8'h00},
      // stray word after a finished key
      '{32'h0badf00d, 1'b0, 16'h1234, 32'h87654321, 1'b0, 32'h0, 8'h00},
      // new key abandons one in flight
      '{32'h11111111, 1'b1, 16'h0005, 32'h00000001, 1'b0, 32'h0, 8'h00},
      '{32'h22222222, 1'b0, 16'h0000, 32'h00000000, 1'b0, 32'h0, 8'h00},
      '{32'h80000000, 1'b1, 16'h0002, 32'h5a5a5a5a, 1'b0, 32'h0, 8'h00},
      '{32'h7fffffff, 1'b0, 16'h0000, 32'h00000000, 1'b0, 32'h0, 8'h00},
      // longest key, abandoned by an empty key
      '{32'h00000000, 1'b1, 16'hffff, 32'hffffffff, 1'b0, 32'h0, 8'h00},
      '{32'hdeadbeef, 1'b0, 16'h0000, 32'h00000000, 1'b0, 32'h0, 8'h00},
      '{32'h00000000, 1'b1, 16'h0000, 32'h00000000, 1'b1, 32'hdeadbeef, 8'hef}
   };

   word_array_hash #(
      .BUCKET_BITS(BUCKET_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_key_word(req_key_word),
      .req_first_word(req_first_word),
      .req_word_count(req_word_count),
      .req_seed(req_seed),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_hash_value(rsp_hash_value),
      .rsp_bucket_index(rsp_bucket_index)
   );

   always #5 clock = ~clock;

   function automatic logic [31:0] rot32(input logic [31:0] x, input int n);
      logic [63:0] d;
      d = {x, x} << n;
      return d[63:32];
   endfunction

   function automatic abc_type mix_group(input abc_type v);
      logic [31:0] a, b, c;
      a = v.a; b = v.b; c = v.c;
      a = a - c; a = a ^ rot32(c, 4);  c = c + b;
      b = b - a; b = b ^ rot32(a, 6);  a = a + c;
      c = c - b; c = c ^ rot32(b, 8);  b = b + a;
      a = a - c; a = a ^ rot32(c, 16); c = c + b;
      b = b - a; b = b ^ rot32(a, 19); a = a + c;
      c = c - b; c = c ^ rot32(b, 4);  b = b + a;
      v.a = a; v.b = b; v.c = c;
      return v;
   endfunction

   function automatic abc_type final_rounds(input abc_type v);
      logic [31:0] a, b, c;
      a = v.a; b = v.b; c = v.c;
      c = c ^ b; c = c - rot32(b, 14);
      a = a ^ c; a = a - rot32(c, 11);
      b = b ^ a; b = b - rot32(a, 25);
      c = c ^ b; c = c - rot32(b, 16);
      a = a ^ c; a = a - rot32(c, 4);
      b = b ^ a; b = b - rot32(a, 14);
      c = c ^ b; c = c - rot32(b, 24);
      v.a = a; v.b = b; v.c = c;
      return v;
   endfunction

   function automatic logic [7:0] bucket_of(input logic [31:0] h);
      logic [63:0] mask;
      mask = (64'd1 << BUCKET_BITS) - 64'd1;
      return 8'(h & mask[31:0]);
   endfunction

   // absorbs one accepted item; returns 1 when it finishes a key
   function automatic bit hash_absorb(input logic [31:0] word, input logic first,
                                      input logic [15:0] count, input logic [31:0] seed,
                                      output logic [31:0] h);
      logic [31:0] start;
      start = HashInit + {14'd0, count, 2'b00} + seed;
      h = '0;
      if (first) begin
         key_abc.a = start;
         key_abc.b = start;
         key_abc.c = start;
         key_words_left = count;
         key_slot = SlotA;
         if (count == 0) begin
            h = start;
            return 1'b1;
         end
      end
      if (key_words_left == 0)
         return 1'b0;
      case (key_slot)
         SlotB: key_abc.b = key_abc.b + word;
         SlotC: key_abc.c = key_abc.c + word;
         default: key_abc.a = key_abc.a + word;
      endcase
      key_slot = (key_slot == 2'd3) ? SlotB : key_slot + 2'd1;
      key_words_left = key_words_left - 16'd1;
      if (key_words_left == 0) begin
         key_abc = final_rounds(key_abc);
         key_slot = SlotA;
         h = key_abc.c;
         return 1'b1;
      end
      if (key_slot == 2'd3) begin
         key_abc = mix_group(key_abc);
         key_slot = SlotA;
      end
      return 1'b0;
   endfunction

   task automatic report_failure(input string what);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t: %s", $time, what);
   endtask

   // predict on every accepted item, check every accepted result
   always @(posedge clock) begin
      hash_result_type want;
      logic [31:0]     h;
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (hash_absorb(req_key_word, req_first_word, req_word_count, req_seed, h)) begin
               want.hash = h;
               want.bucket = bucket_of(h);
               if (drv_fixed) begin
                  want.hash = drv_fixed_hash;
                  want.bucket = drv_fixed_bucket;
               end
               due_hashes.push_back(want);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (due_hashes.size() == 0) begin
               report_failure($sformatf("unexpected item: hash_value %h bucket_index %h",
                                        rsp_hash_value, rsp_bucket_index));
            end else begin
               want = due_hashes.pop_front();
               if (rsp_hash_value !== want.hash)
                  report_failure($sformatf("hash_value: expected %h, got %h",
                                           want.hash, rsp_hash_value));
               if (rsp_bucket_index !== want.bucket)
                  report_failure($sformatf("bucket_index: expected %h, got %h",
                                           want.bucket, rsp_bucket_index));
            end
         end
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_start) begin
         hold_left = 300;
         hold_start = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (idle_mode == IdleReceiver) begin
         rsp_ready <= ($urandom_range(99) >= 49);
      end else if (idle_mode == IdleBoth) begin
         rsp_ready <= ($urandom_range(99) >= 25);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic bit sender_waits();
      if (idle_mode == IdleSender)
         return $urandom_range(99) < 49;
      if (idle_mode == IdleBoth)
         return $urandom_range(99) < 25;
      return 1'b0;
   endfunction

   function automatic logic [31:0] any_word();
      case ($urandom_range(9))
         0: return 32'h00000000;
         1: return 32'hffffffff;
         default: return $urandom;
      endcase
   endfunction

   // returns at the rising edge where the item is taken
   task automatic send_item(input logic [31:0] word, input logic first,
                            input logic [15:0] count, input logic [31:0] seed,
                            input logic fixed, input logic [31:0] fixed_hash,
                            input logic [7:0] fixed_bucket);
      @(negedge clock);
      while (sender_waits()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_key_word <= word;
      req_first_word <= first;
      req_word_count <= count;
      req_seed <= seed;
      drv_fixed <= fixed;
      drv_fixed_hash <= fixed_hash;
      drv_fixed_bucket <= fixed_bucket;
      do @(posedge clock); while (!req_ready);
   endtask

   // sends the first items of a key of len words (all of them when items == len)
   task automatic send_key(input int len, input int items);
      send_item(any_word(), 1'b1, 16'(len), any_word(), 1'b0, '0, '0);
      for (int i = 1; i < items; i++)
         send_item(any_word(), 1'b0, 16'($urandom), $urandom, 1'b0, '0, '0);
   endtask

   task automatic run_traffic(input int quota);
      int sent, pick, len, items;
      sent = 0;
      while (sent < quota) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            // stray word, or one more word for an abandoned key
            send_item(any_word(), 1'b0, 16'($urandom), $urandom, 1'b0, '0, '0);
            sent += 1;
         end else if (pick < 18) begin
            len = $urandom_range(65535);
            if (len < 2)
               len = 2;
            items = $urandom_range(1, (len > 7) ? 6 : len - 1);
            send_key(len, items);
            sent += items;
         end else begin
            len = (pick < 28) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            items = (len == 0) ? 1 : len;
            send_key(len, items);
            sent += items;
         end
      end
   endtask

   initial begin
      int len;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send_item(directed[i].word, directed[i].first, directed[i].count, directed[i].seed,
                   directed[i].fixed, directed[i].fixed_hash, directed[i].fixed_bucket);

      idle_mode = IdleNone;
      run_traffic(90);
      idle_mode = IdleSender;
      run_traffic(90);
      idle_mode = IdleReceiver;
      run_traffic(90);
      idle_mode = IdleBoth;
      run_traffic(90);

      // receiver holds off while short keys keep coming, so the queue fills
      idle_mode = IdleNone;
      hold_start = 1'b1;
      for (int i = 0; i < 30; i++) begin
         len = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
         send_key(len, (len == 0) ? 1 : len);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (due_hashes.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);

      if (due_hashes.size() != 0)
         report_failure($sformatf("%0d results never arrived", due_hashes.size()));
      if (fail_count == 0)
         $display("word_array_hash_tb: PASS");
      else
         $display("word_array_hash_tb: FAIL");
      $finish;
   end

   initial begin
      #2000000;
      $display("word_array_hash_tb: FAIL");
      $finish;
   end

endmodule
